/* design/nbue_pkg.sv */
// Shared types and constants for the nine-bit UART escape bridge.
`default_nettype none

package nbue_pkg;

  // Input event codes
  localparam logic [1:0] KIND_RX     = 2'd0;
  localparam logic [1:0] KIND_HOST   = 2'd1;
  localparam logic [1:0] KIND_TXDONE = 2'd2;

  // Escape protocol bytes
  localparam logic [7:0] ESC_CODE  = 8'hFF;
  localparam logic [7:0] HIGH_CODE = 8'h01;

  // Job codes handed from the front to the back
  localparam logic [1:0] JOB_PLAIN = 2'd0;  // one host byte
  localparam logic [1:0] JOB_ESC2  = 2'd1;  // FF FF
  localparam logic [1:0] JOB_HIGH3 = 2'd2;  // FF 01 d
  localparam logic [1:0] JOB_LINE  = 2'd3;  // one line-side beat

  // Job queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       line_valid;
    logic       line_ninth;
    logic       drv;
  } job_t;

endpackage

`default_nettype wire

/* design/nbue_front.sv */
// Front end: accepts events, runs the host-byte decoder and builds jobs.
`default_nettype none

module nbue_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire logic [1:0]        kind,
  input  wire logic [7:0]        data,
  input  wire logic              ninth_bit,
  input  wire logic              q_full,
  output logic                   q_push,
  output nbue_pkg::job_t         q_job
);
  import nbue_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ESCAPE = 2'd1;
  localparam logic [1:0] ST_HIGH   = 2'd2;

  logic [1:0] decode_state, decode_state_next;
  logic       driver_on, driver_on_next;
  logic       accept;
  logic       lv, ln;

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;

  // Host-byte decoder
  always_comb begin
    decode_state_next = decode_state;
    lv = 1'b0;
    ln = 1'b0;
    unique case (decode_state)
      ST_ESCAPE: begin
        if (data == HIGH_CODE) begin
          decode_state_next = ST_HIGH;
        end else if (data == ESC_CODE) begin
          decode_state_next = ST_IDLE;
          lv = 1'b1;
        end else begin
          decode_state_next = ST_IDLE;  // drop illegal byte
        end
      end
      ST_HIGH: begin
        decode_state_next = ST_IDLE;
        lv = 1'b1;
        ln = 1'b1;
      end
      default: begin
        if (data == ESC_CODE) begin
          decode_state_next = ST_ESCAPE;
        end else begin
          decode_state_next = ST_IDLE;
          lv = 1'b1;
        end
      end
    endcase
  end

  // Classify the event into a job
  always_comb begin
    driver_on_next = driver_on;
    q_push         = 1'b0;
    q_job          = '0;
    q_job.data     = data;
    q_job.drv      = driver_on;
    case (kind)
      KIND_RX: begin
        q_push = accept;
        if (ninth_bit) begin
          q_job.op = JOB_HIGH3;
        end else if (data == ESC_CODE) begin
          q_job.op = JOB_ESC2;
        end else begin
          q_job.op = JOB_PLAIN;
        end
      end
      KIND_HOST: begin
        q_push           = accept;
        driver_on_next   = 1'b1;
        q_job.op         = JOB_LINE;
        q_job.line_valid = lv;
        q_job.line_ninth = ln;
        q_job.drv        = 1'b1;
      end
      KIND_TXDONE: begin
        q_push         = accept;
        driver_on_next = 1'b0;
        q_job.op       = JOB_LINE;
        q_job.drv      = 1'b0;
      end
      default: begin
        q_push = 1'b0;  // unused code: drop
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_state <= ST_IDLE;
      driver_on    <= 1'b0;
    end else if (accept) begin
      driver_on <= driver_on_next;
      if (kind == KIND_HOST) begin
        decode_state <= decode_state_next;
      end
    end
  end

endmodule

`default_nettype wire

/* design/nbue_queue.sv */
// Short job queue between the front and back ends.
`default_nettype none

module nbue_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire nbue_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output nbue_pkg::job_t      head_job
);
  import nbue_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/nbue_back.sv */
// Back end: expands jobs into result beats and holds the output register.
`default_nettype none

module nbue_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire nbue_pkg::job_t head_job,
  output logic                pop,
  output logic                result_valid,
  input  wire logic           result_stall,
  output logic                host_valid,
  output logic [7:0]          host_byte,
  output logic                line_valid,
  output logic [7:0]          line_byte,
  output logic                line_ninth,
  output logic                driver_enable,
  output logic                last
);
  import nbue_pkg::*;

  logic [1:0] beat_idx;
  logic       load;
  logic       b_hv, b_lv, b_ln, b_last;
  logic [7:0] b_hb, b_lb;

  assign load = head_valid && (!result_valid || !result_stall);
  assign pop  = load && b_last;

  // Beat selection for the job at the queue head
  always_comb begin
    b_hv   = 1'b0;
    b_hb   = '0;
    b_lv   = 1'b0;
    b_lb   = '0;
    b_ln   = 1'b0;
    b_last = 1'b1;
    unique case (head_job.op)
      JOB_PLAIN: begin
        b_hv = 1'b1;
        b_hb = head_job.data;
      end
      JOB_ESC2: begin
        b_hv   = 1'b1;
        b_hb   = (beat_idx == 2'd0) ? ESC_CODE : head_job.data;
        b_last = (beat_idx == 2'd1);
      end
      JOB_HIGH3: begin
        b_hv   = 1'b1;
        b_hb   = (beat_idx == 2'd0) ? ESC_CODE :
                 (beat_idx == 2'd1) ? HIGH_CODE : head_job.data;
        b_last = (beat_idx == 2'd2);
      end
      default: begin
        b_lv = head_job.line_valid;
        b_lb = head_job.line_valid ? head_job.data : 8'd0;
        b_ln = head_job.line_valid && head_job.line_ninth;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      beat_idx     <= '0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        beat_idx     <= b_last ? 2'd0 : beat_idx + 2'd1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      host_valid    <= b_hv;
      host_byte     <= b_hb;
      line_valid    <= b_lv;
      line_byte     <= b_lb;
      line_ninth    <= b_ln;
      driver_enable <= head_job.drv;
      last          <= b_last;
    end
  end

endmodule

`default_nettype wire

/* design/nine_bit_uart_escape_bridge.sv */
// Top level of the nine-bit UART escape bridge.
//
// Bridges a host byte stream to a 9-bit serial line with 0xFF byte stuffing.
// Each input beat is one event: a received line character (kind 0), a host
// byte to transmit (kind 1) or a transmit-complete notice (kind 2); kind 3 is
// ignored and yields nothing. A received character becomes one to three host
// beats (d, FF FF, or FF 01 d when its ninth bit is set). A host byte yields
// one beat that carries the rebuilt line character, if any, from the
// idle/escape/high decoder; the first host byte raises driver_enable and a
// transmit-complete beat lowers it. Every result beat carries driver_enable
// as it stood after its event, and last marks the final beat of an event.
// The front end takes one event per cycle as long as its four-entry job queue
// has room; the back end emits one result beat per cycle from its output
// register while result_stall is low, and an event expands to one to three
// beats (three for a received character with its ninth bit set).
// Both sides use valid/stall: a beat moves when valid is high and stall low.
`default_nettype none

module nine_bit_uart_escape_bridge (
  input  wire logic       clk,
  input  wire logic       rst,
  // event channel
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [1:0] kind,
  input  wire logic [7:0] data,
  input  wire logic       ninth_bit,
  // result channel
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic            host_valid,
  output logic [7:0]      host_byte,
  output logic            line_valid,
  output logic [7:0]      line_byte,
  output logic            line_ninth,
  output logic            driver_enable,
  output logic            last
);
  import nbue_pkg::*;

  // Jobs flow front -> queue -> back
  logic q_full;
  logic q_push;
  job_t q_job;
  logic q_pop;
  logic head_valid;
  job_t head_job;

  // Classify events and keep the decoder / driver state
  nbue_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .kind       (kind),
    .data       (data),
    .ninth_bit  (ninth_bit),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_job)
  );

  // Decouple event intake from beat output
  nbue_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Expand each job into its result beats
  nbue_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_job      (head_job),
    .pop           (q_pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .host_valid    (host_valid),
    .host_byte     (host_byte),
    .line_valid    (line_valid),
    .line_byte     (line_byte),
    .line_ninth    (line_ninth),
    .driver_enable (driver_enable),
    .last          (last)
  );

endmodule

`default_nettype wire
